>>> hdl/icle_pkg.sv
// Shared types, constants and controller interface of the idle-count load estimator.
package icle_pkg;

  localparam int unsigned TIME_W = 48;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned IVL_W  = 24;
  localparam int unsigned LOAD_W = 15;
  localparam int unsigned PROD_W = CNT_W + IVL_W;
  localparam int unsigned NUM_W  = TIME_W;
  localparam int unsigned DIVD_W = PROD_W;
  localparam int unsigned DIVS_W = TIME_W;

  localparam logic [IVL_W-1:0]  IVL_RESET = IVL_W'(1000000);
  localparam logic [LOAD_W-1:0] FULL_Q8   = LOAD_W'(25600);

  localparam logic CMD_SAMPLE  = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [TIME_W-1:0] now_us;
    logic [CNT_W-1:0]  idle_count_core0;
    logic [CNT_W-1:0]  idle_count_core1;
  } in_req_t;

  typedef struct packed {
    logic              updated;
    logic [LOAD_W-1:0] load_percent_q8;
    logic [CNT_W-1:0]  idle_delta_norm;
    logic [CNT_W-1:0]  idle_baseline;
  } out_req_t;

  typedef struct packed {
    logic cap;
    logic restart;
    logic take;
    logic mul;
    logic div_go;
    logic div_sel_load;
    logic norm_raw;
    logic norm_div;
    logic max_upd;
    logic lmul;
    logic load_set;
    logic emit;
    logic emit_upd;
  } icle_cmd_t;

  typedef struct packed {
    logic is_restart;
    logic elapsed_ok;
    logic elapsed_zero;
    logic max_zero;
    logic div_done;
    logic out_free;
  } icle_sts_t;

endpackage

>>> hdl/idle_count_load_estimator.sv
// Top level of the idle-count processor load estimator.
//
//   port group   dir  handshake            payload
//   in_*         in   in_valid / in_stall  in_req_t  (cmd, now_us, two idle counts)
//   out_*        out  out_valid/ out_stall out_req_t (updated, load, delta, baseline)
//   cfg_*        in   cfg_we               sample_interval_us, 24 bits
//
// A restart request or a sample inside the interval goes from the check straight to its result.
// A sample that updates the estimate makes at most two passes through the one
// radix-2 divider (normalization, then the load quotient).
// A result waits in the output register while out_stall is high; the next request
// is processed meanwhile and holds only at its own result.
// rst_n is synchronous; reset leaves the interval at 1000000 and the estimator state and out_valid at zero.
module idle_count_load_estimator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  icle_pkg::in_req_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output icle_pkg::out_req_t          out_data,
  input  logic                        cfg_we,
  input  logic [icle_pkg::IVL_W-1:0]  cfg_wdata
);

  icle_pkg::icle_cmd_t cmd;
  icle_pkg::icle_sts_t sts;

  icle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  icle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

>>> hdl/icle_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module icle_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [icle_pkg::DIVD_W-1:0]      dividend,
  input  logic [icle_pkg::DIVS_W-1:0]      divisor,
  output logic [icle_pkg::DIVD_W-1:0]      quot,
  output logic                             done
);

  localparam int unsigned CNT_BITS = $clog2(icle_pkg::DIVD_W + 1);

  logic [icle_pkg::DIVD_W-1:0] q_r;
  logic [icle_pkg::DIVS_W-1:0] rem_r;
  logic [icle_pkg::DIVS_W-1:0] dvs_r;
  logic [CNT_BITS-1:0]         cnt_r;
  logic                        busy_r;
  logic                        done_r;

  logic [icle_pkg::DIVS_W:0]   trial;
  logic [icle_pkg::DIVS_W:0]   diff;
  logic                        ge;

  assign trial = {rem_r, q_r[icle_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_BITS'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(icle_pkg::DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[icle_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? diff[icle_pkg::DIVS_W-1:0] : trial[icle_pkg::DIVS_W-1:0];
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

>>> hdl/icle_dp.sv
// Datapath: request capture, estimator state, multipliers, shared divider, result register.
module icle_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [icle_pkg::IVL_W-1:0]       cfg_wdata,
  input  icle_pkg::in_req_t                in_data,
  output icle_pkg::out_req_t               out_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  input  icle_pkg::icle_cmd_t              cmd,
  output icle_pkg::icle_sts_t              sts
);

  logic [icle_pkg::IVL_W-1:0]  ivl_r;
  logic                        cmd_r;
  logic [icle_pkg::TIME_W-1:0] now_r;
  logic [icle_pkg::CNT_W-1:0]  total_r;
  logic [icle_pkg::TIME_W-1:0] last_time_r;
  logic [icle_pkg::CNT_W-1:0]  prev_total_r;
  logic [icle_pkg::CNT_W-1:0]  max_r;
  logic [icle_pkg::CNT_W-1:0]  last_delta_r;
  logic [icle_pkg::LOAD_W-1:0] load_r;
  logic [icle_pkg::CNT_W-1:0]  delta_r;
  logic [icle_pkg::TIME_W-1:0] elapsed_r;
  logic [icle_pkg::PROD_W-1:0] prod_r;
  logic [icle_pkg::CNT_W-1:0]  norm_r;
  logic [icle_pkg::NUM_W-1:0]  num_r;
  icle_pkg::out_req_t          out_r;
  logic                        out_valid_r;
  logic                        out_valid_nxt;

  logic [icle_pkg::TIME_W-1:0] elapsed;
  logic [icle_pkg::DIVD_W-1:0] div_dividend;
  logic [icle_pkg::DIVS_W-1:0] div_divisor;
  logic [icle_pkg::DIVD_W-1:0] div_quot;
  logic                        div_done;

  assign elapsed = now_r - last_time_r;

  assign div_dividend = cmd.div_sel_load ? icle_pkg::DIVD_W'(num_r) : prod_r;
  assign div_divisor  = cmd.div_sel_load ? icle_pkg::DIVS_W'(max_r) : elapsed_r;

  icle_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivl_r        <= icle_pkg::IVL_RESET;
      last_time_r  <= '0;
      prev_total_r <= '0;
      max_r        <= '0;
      last_delta_r <= '0;
      load_r       <= '0;
    end else begin
      if (cfg_we) begin
        ivl_r <= cfg_wdata;
      end
      if (cmd.restart || cmd.take) begin
        last_time_r <= now_r;
      end
      if (cmd.take) begin
        prev_total_r <= total_r;
      end
      if (cmd.max_upd) begin
        last_delta_r <= norm_r;
        if (norm_r > max_r) begin
          max_r <= norm_r;
        end
      end
      if (cmd.load_set) begin
        load_r <= div_quot[icle_pkg::LOAD_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cmd_r   <= in_data.cmd;
      now_r   <= in_data.now_us;
      total_r <= in_data.idle_count_core0 + in_data.idle_count_core1;
    end
    if (cmd.take) begin
      delta_r   <= total_r - prev_total_r;
      elapsed_r <= elapsed;
    end
    if (cmd.mul) begin
      prod_r <= icle_pkg::PROD_W'(delta_r) * icle_pkg::PROD_W'(ivl_r);
    end
    if (cmd.norm_raw) begin
      norm_r <= delta_r;
    end else if (cmd.norm_div) begin
      norm_r <= div_quot[icle_pkg::CNT_W-1:0];
    end
    if (cmd.lmul) begin
      num_r <= icle_pkg::NUM_W'(icle_pkg::FULL_Q8) * icle_pkg::NUM_W'(max_r - norm_r)
             + icle_pkg::NUM_W'(max_r[icle_pkg::CNT_W-1:1]);
    end
    if (cmd.emit) begin
      out_r.updated         <= cmd.emit_upd;
      out_r.load_percent_q8 <= load_r;
      out_r.idle_delta_norm <= last_delta_r;
      out_r.idle_baseline   <= max_r;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign sts.is_restart   = (cmd_r == icle_pkg::CMD_RESTART);
  assign sts.elapsed_ok   = (elapsed >= icle_pkg::TIME_W'(ivl_r));
  assign sts.elapsed_zero = (elapsed_r == '0);
  assign sts.max_zero     = (max_r == '0);
  assign sts.div_done     = div_done;
  assign sts.out_free     = !out_valid_r || !out_stall;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

>>> hdl/icle_ctrl.sv
// Controller state machine sequencing one request through the datapath.
module icle_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  icle_pkg::icle_sts_t  sts,
  output icle_pkg::icle_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_NORM,
    S_NDIV,
    S_MAX,
    S_LMUL,
    S_LDIV_GO,
    S_LDIV,
    S_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   upd_r;
  logic   upd_nxt;

  always_comb begin
    state_nxt = state_r;
    upd_nxt   = upd_r;
    cmd       = '0;
    cmd.emit_upd = upd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.is_restart) begin
          cmd.restart = 1'b1;
          upd_nxt     = 1'b0;
          state_nxt   = S_EMIT;
        end else if (!sts.elapsed_ok) begin
          upd_nxt   = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          cmd.take  = 1'b1;
          upd_nxt   = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (sts.elapsed_zero) begin
          cmd.norm_raw = 1'b1;
          state_nxt    = S_MAX;
        end else begin
          cmd.div_go = 1'b1;
          state_nxt  = S_NDIV;
        end
      end
      S_NDIV: begin
        if (sts.div_done) begin
          cmd.norm_div = 1'b1;
          state_nxt    = S_MAX;
        end
      end
      S_MAX: begin
        cmd.max_upd = 1'b1;
        state_nxt   = S_LMUL;
      end
      S_LMUL: begin
        if (sts.max_zero) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.lmul  = 1'b1;
          state_nxt = S_LDIV_GO;
        end
      end
      S_LDIV_GO: begin
        cmd.div_go       = 1'b1;
        cmd.div_sel_load = 1'b1;
        state_nxt        = S_LDIV;
      end
      S_LDIV: begin
        cmd.div_sel_load = 1'b1;
        if (sts.div_done) begin
          cmd.load_set = 1'b1;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      upd_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      upd_r   <= upd_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

>>> hdl/icle_chk.sv
// Port-level checker for the load estimator, bound to the top level.
module icle_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input icle_pkg::out_req_t          out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.load_percent_q8 <= icle_pkg::FULL_Q8)
    else $error("load above 100 percent");

  a_delta_le_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.idle_delta_norm <= out_data.idle_baseline)
    else $error("normalized delta above baseline");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while another is in flight");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind idle_count_load_estimator icle_chk u_icle_chk (.*);
